### sv/mbrp_pkg.sv
package mbrp_pkg;

	localparam int DEF_WINDOW_BYTES    = 9;
	localparam int DEF_MIN_FRAME_BYTES = 7;

	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int POS_W      = 18;
	localparam int SPEED_W    = 32;
	localparam int WORD_W     = 16;
	localparam int SPAN_W     = 17;
	localparam int HALF_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int CRC_W      = 16;

	// frame kinds as seen on the result channel
	localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPEED    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SPAN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_HALF  = 3'd4;

	localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS = 8'd1;
	localparam logic [BYTE_W-1:0] RST_READ_CODE      = 8'd3;
	localparam logic [BYTE_W-1:0] RST_WRITE_CODE     = 8'd6;
	localparam logic [SPAN_W-1:0] RST_POSITION_SPAN  = 17'd4096;
	localparam logic [HALF_W-1:0] RST_POSITION_HALF  = 15'd2048;

	localparam logic [BYTE_W-1:0] LEN_POSITION = 8'h02;
	localparam logic [BYTE_W-1:0] LEN_SPEED    = 8'h04;

	localparam int POS_FRAME_BYTES   = 7;
	localparam int SPEED_FRAME_BYTES = 9;
	localparam int ECHO_FRAME_BYTES  = 8;
	// index of the last byte covered by the crc
	localparam int POS_CRC_LAST      = 4;
	localparam int SPEED_CRC_LAST    = 6;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CRC,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_byte;
		logic drop_one;
		logic drop_frame;
		logic crc_init;
		logic crc_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_go;
		logic head_bad;
		logic is_read;
		logic frame_short;
		logic crc_last;
		logic crc_ok;
		logic out_free;
	} status_t;

endpackage

### sv/mbrp_ifs.sv
interface mbrp_rx_if
	import mbrp_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbrp_reply_if
	import mbrp_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic        [KIND_W-1:0]  frame_kind;
	logic signed [POS_W-1:0]   position;
	logic signed [SPEED_W-1:0] speed_raw;
	logic        [WORD_W-1:0]  echo_register;
	logic        [WORD_W-1:0]  echo_value;

	modport source (
		output valid, output frame_kind, output position, output speed_raw,
		output echo_register, output echo_value, input ready
	);
	modport sink (
		input valid, input frame_kind, input position, input speed_raw,
		input echo_register, input echo_value, output ready
	);
endinterface

### sv/mbrp_ctrl.sv
module mbrp_ctrl
	import mbrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (!status.scan_go) state_next = ST_IDLE;
				else if (status.head_bad) state_next = ST_SCAN;
				else if (status.frame_short) state_next = ST_IDLE;
				else if (status.is_read) state_next = ST_CRC;
				else state_next = ST_EMIT;
			end
			ST_CRC: begin
				if (status.crc_last) state_next = ST_CMP;
			end
			ST_CMP: begin
				state_next = status.crc_ok ? ST_EMIT : ST_SCAN;
			end
			ST_EMIT: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_byte = in_valid;
			end
			ST_SCAN: begin
				cmd.drop_one = status.scan_go && status.head_bad;
				cmd.crc_init = status.scan_go && !status.head_bad &&
					!status.frame_short && status.is_read;
			end
			ST_CRC: begin
				cmd.crc_step = 1'b1;
			end
			ST_CMP: begin
				cmd.drop_one = !status.crc_ok;
			end
			ST_EMIT: begin
				cmd.load_out   = status.out_free;
				cmd.drop_frame = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### sv/mbrp_dp.sv
module mbrp_dp
	import mbrp_pkg::*;
#(
	parameter int WINDOW_BYTES    = DEF_WINDOW_BYTES,
	parameter int MIN_FRAME_BYTES = DEF_MIN_FRAME_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  cmd_t                  cmd,
	output status_t               status,
	mbrp_reply_if.source          reply
);

	localparam int IDX_W  = $clog2(WINDOW_BYTES);
	localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_BYTES);
	localparam logic [FILL_W-1:0] FILL_MIN  = FILL_W'(MIN_FRAME_BYTES);
	localparam logic [FILL_W-1:0] FILL_HEAD = FILL_W'(3);

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	logic [BYTE_W-1:0] device_address_q, read_code_q, write_code_q;
	logic [SPAN_W-1:0] position_span_q;
	logic [HALF_W-1:0] position_half_q;

	logic [BYTE_W-1:0] win_q [WINDOW_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [CRC_W-1:0]  crc_q;
	logic [IDX_W-1:0]  idx_q;

	logic [BYTE_W-1:0] sh1 [WINDOW_BYTES];
	logic [BYTE_W-1:0] sh7 [WINDOW_BYTES];
	logic [BYTE_W-1:0] sh8 [WINDOW_BYTES];
	logic [BYTE_W-1:0] sh9 [WINDOW_BYTES];

	logic              fc_read, fc_write, len2, len4, is_speed;
	logic [FILL_W-1:0] flen, drop_n;

	logic                      out_valid_q;
	logic        [KIND_W-1:0]  kind_q;
	logic signed [POS_W-1:0]   pos_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic        [WORD_W-1:0]  ereg_q, eval_q;

	logic signed [POS_W-1:0] raw, pos_wrap;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= RST_DEVICE_ADDRESS;
			read_code_q      <= RST_READ_CODE;
			write_code_q     <= RST_WRITE_CODE;
			position_span_q  <= RST_POSITION_SPAN;
			position_half_q  <= RST_POSITION_HALF;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[BYTE_W-1:0];
				CFG_READ_CODE:      read_code_q      <= cfg_data[BYTE_W-1:0];
				CFG_WRITE_CODE:     write_code_q     <= cfg_data[BYTE_W-1:0];
				CFG_POSITION_SPAN:  position_span_q  <= cfg_data[SPAN_W-1:0];
				CFG_POSITION_HALF:  position_half_q  <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// window shifted down by each possible drop amount
	for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_shift
		if (i + 1 < WINDOW_BYTES) begin : g_s1
			assign sh1[i] = win_q[IDX_W'(i + 1)];
		end else begin : g_s1h
			assign sh1[i] = win_q[i];
		end
		if (i + POS_FRAME_BYTES < WINDOW_BYTES) begin : g_s7
			assign sh7[i] = win_q[IDX_W'(i + POS_FRAME_BYTES)];
		end else begin : g_s7h
			assign sh7[i] = win_q[i];
		end
		if (i + ECHO_FRAME_BYTES < WINDOW_BYTES) begin : g_s8
			assign sh8[i] = win_q[IDX_W'(i + ECHO_FRAME_BYTES)];
		end else begin : g_s8h
			assign sh8[i] = win_q[i];
		end
		if (i + SPEED_FRAME_BYTES < WINDOW_BYTES) begin : g_s9
			assign sh9[i] = win_q[IDX_W'(i + SPEED_FRAME_BYTES)];
		end else begin : g_s9h
			assign sh9[i] = win_q[i];
		end
	end

	// head decode; equal codes count as a read
	assign fc_read  = (win_q[1] == read_code_q);
	assign fc_write = (win_q[1] == write_code_q);
	assign len2     = (win_q[2] == LEN_POSITION);
	assign len4     = (win_q[2] == LEN_SPEED);
	assign is_speed = fc_read && len4;
	assign flen     = !fc_read ? FILL_W'(ECHO_FRAME_BYTES)
		: (len4 ? FILL_W'(SPEED_FRAME_BYTES) : FILL_W'(POS_FRAME_BYTES));
	assign drop_n   = cmd.drop_frame ? flen : FILL_W'(1);

	assign status.scan_go     = (fill_q >= FILL_MIN) && (fill_q >= FILL_HEAD);
	assign status.head_bad    = (win_q[0] != device_address_q) ||
		(!fc_read && !fc_write) || (fc_read && !len2 && !len4);
	assign status.is_read     = fc_read;
	assign status.frame_short = (fill_q < flen);
	assign status.crc_last    = (idx_q == (len4 ? IDX_W'(SPEED_CRC_LAST)
		: IDX_W'(POS_CRC_LAST)));
	assign status.crc_ok      = len4
		? (win_q[7] == crc_q[7:0] && win_q[8] == crc_q[15:8])
		: (win_q[5] == crc_q[7:0] && win_q[6] == crc_q[15:8]);
	assign status.out_free    = !out_valid_q || reply.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.load_byte) begin
			if (fill_q != FILL_FULL) fill_q <= fill_q + FILL_W'(1);
		end else if (cmd.drop_one || cmd.drop_frame) begin
			fill_q <= (drop_n >= fill_q) ? '0 : fill_q - drop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			if (fill_q == FILL_FULL) begin
				for (int i = 0; i < WINDOW_BYTES - 1; i++) win_q[i] <= sh1[i];
				win_q[WINDOW_BYTES-1] <= rx_byte;
			end else begin
				win_q[fill_q[IDX_W-1:0]] <= rx_byte;
			end
		end else if (cmd.drop_frame) begin
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				win_q[i] <= !fc_read ? sh8[i] : (len4 ? sh9[i] : sh7[i]);
			end
		end else if (cmd.drop_one) begin
			for (int i = 0; i < WINDOW_BYTES; i++) win_q[i] <= sh1[i];
		end
	end

	// crc one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			idx_q <= '0;
		end else if (cmd.crc_init) begin
			crc_q <= CRC_INIT;
			idx_q <= '0;
		end else if (cmd.crc_step) begin
			crc_q <= crc_byte(crc_q, win_q[idx_q]);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// position with half-span wrap, 18-bit wrap on the difference
	assign raw      = POS_W'($signed({win_q[3], win_q[4]}));
	assign pos_wrap = (raw > $signed({3'b000, position_half_q}))
		? raw - $signed({1'b0, position_span_q}) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q  <= !fc_read ? KIND_ECHO : (is_speed ? KIND_SPEED : KIND_POSITION);
			pos_q   <= (fc_read && !len4) ? pos_wrap : '0;
			speed_q <= is_speed ? $signed({win_q[3], win_q[4], win_q[5], win_q[6]}) : '0;
			ereg_q  <= !fc_read ? {win_q[2], win_q[3]} : '0;
			eval_q  <= !fc_read ? {win_q[4], win_q[5]} : '0;
		end
	end

	assign reply.valid         = out_valid_q;
	assign reply.frame_kind    = kind_q;
	assign reply.position      = pos_q;
	assign reply.speed_raw     = speed_q;
	assign reply.echo_register = ereg_q;
	assign reply.echo_value    = eval_q;

endmodule

### sv/modbus_encoder_reply_parser_core.sv
// a byte beat is accepted only in the idle state; the scan state then runs the head check,
// dropping one byte per failed check; a write echo goes to the result register with no
// crc check, a position or speed reply first runs the crc loop (one byte a cycle), and
// a failed crc drops one byte and rescans; loading waits while the result register is full
// bytes wait until the parser is back in idle; a result register decouples the reply side
// reset: window empty (fill count cleared, contents left as is), registers to defaults
module modbus_encoder_reply_parser_core
	import mbrp_pkg::*;
#(
	parameter int WINDOW_BYTES    = DEF_WINDOW_BYTES,
	parameter int MIN_FRAME_BYTES = DEF_MIN_FRAME_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mbrp_rx_if.sink               rx,
	mbrp_reply_if.source          reply,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	mbrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mbrp_dp #(
		.WINDOW_BYTES    (WINDOW_BYTES),
		.MIN_FRAME_BYTES (MIN_FRAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.status    (status),
		.reply     (reply)
	);

endmodule

### bench/tb_modbus_encoder_reply_parser_core.sv
`timescale 1ns / 100ps

module tb_modbus_encoder_reply_parser_core;
	import mbrp_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int WINDOW_LIMIT  = DEF_WINDOW_BYTES;
	localparam int HUNT_BYTES    = DEF_MIN_FRAME_BYTES;
	localparam int PHASE_BYTES   = 60;
	localparam int RANDOM_PHASES = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	typedef struct packed {
		logic        [KIND_W-1:0]  kind;
		logic signed [POS_W-1:0]   position;
		logic signed [SPEED_W-1:0] speed;
		logic        [WORD_W-1:0]  echo_reg;
		logic        [WORD_W-1:0]  echo_val;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbrp_rx_if    rx_ch ();
	mbrp_reply_if reply_ch ();

	modbus_encoder_reply_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.reply     (reply_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the parser: registers and received byte window
	logic [BYTE_W-1:0] dev_addr;
	logic [BYTE_W-1:0] read_fc;
	logic [BYTE_W-1:0] write_fc;
	logic [SPAN_W-1:0] span;
	logic [HALF_W-1:0] half;
	byte_q_t           rx_window;
	reply_t            pending_replies[$];
	int                error_count = 0;
	bit                calm = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [CRC_W-1:0] modbus_crc(input byte_q_t data, input int count);
		logic [CRC_W-1:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < count; i++) begin
			crc ^= {8'h00, data[i]};
			for (int b = 0; b < 8; b++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		return crc;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] fc;
		logic [BYTE_W-1:0] len;
		logic [CRC_W-1:0]  crc;
		int                flen;
		int                covered;
		int                raw;
		int                pos;
		bit                is_read;
		reply_t            r;
		if (rx_window.size() >= WINDOW_LIMIT)
			rx_window.delete(0);
		rx_window = {rx_window, b};
		while (rx_window.size() >= HUNT_BYTES) begin
			fc      = rx_window[1];
			len     = rx_window[2];
			// a shared function code counts as a read reply
			is_read = (fc == read_fc);
			if (rx_window[0] != dev_addr || (!is_read && fc != write_fc) ||
			    (is_read && len != LEN_POSITION && len != LEN_SPEED)) begin
				rx_window.delete(0);
				continue;
			end
			flen = is_read ? int'(len) + 5 : ECHO_FRAME_BYTES;
			if (rx_window.size() < flen)
				break;
			if (is_read) begin
				covered = int'(len) + 3;
				crc     = modbus_crc(rx_window, covered);
				if ({rx_window[covered + 1], rx_window[covered]} != crc) begin
					rx_window.delete(0);
					continue;
				end
			end
			r = '0;
			if (is_read && len == LEN_POSITION) begin
				raw        = int'($signed({rx_window[3], rx_window[4]}));
				pos        = (raw > int'(half)) ? raw - int'(span) : raw;
				r.kind     = KIND_POSITION;
				r.position = pos[POS_W-1:0];
			end else if (is_read) begin
				r.kind  = KIND_SPEED;
				r.speed = {rx_window[3], rx_window[4], rx_window[5], rx_window[6]};
			end else begin
				r.kind     = KIND_ECHO;
				r.echo_reg = {rx_window[2], rx_window[3]};
				r.echo_val = {rx_window[4], rx_window[5]};
			end
			pending_replies = {pending_replies, r};
			repeat (flen) rx_window.delete(0);
			break;
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		decode_byte(b);
	endtask

	task automatic send_bytes(input byte_q_t q, input int count);
		for (int i = 0; i < count; i++)
			send_byte(q[i]);
	endtask

	function automatic byte_q_t read_frame(input logic [BYTE_W-1:0] addr,
		input logic [BYTE_W-1:0] fc, input logic [BYTE_W-1:0] len,
		input logic [SPEED_W-1:0] payload, input bit bad_crc);
		byte_q_t          q;
		logic [CRC_W-1:0] crc;
		q = {q, addr};
		q = {q, fc};
		q = {q, len};
		if (len == LEN_POSITION) begin
			q = {q, payload[15:8]};
			q = {q, payload[7:0]};
		end else begin
			for (int i = 3; i >= 0; i--)
				q = {q, payload[8*i +: 8]};
		end
		crc = modbus_crc(q, q.size());
		if (bad_crc)
			crc ^= CRC_W'(1) << $urandom_range(0, CRC_W - 1);
		q = {q, crc[7:0]};
		q = {q, crc[15:8]};
		return q;
	endfunction

	function automatic byte_q_t echo_frame(input logic [BYTE_W-1:0] addr,
		input logic [BYTE_W-1:0] fc, input logic [WORD_W-1:0] reg_addr,
		input logic [WORD_W-1:0] value);
		byte_q_t          q;
		logic [CRC_W-1:0] crc;
		q = {q, addr};
		q = {q, fc};
		q = {q, reg_addr[15:8]};
		q = {q, reg_addr[7:0]};
		q = {q, value[15:8]};
		q = {q, value[7:0]};
		crc = modbus_crc(q, q.size());
		q = {q, crc[7:0]};
		q = {q, crc[15:8]};
		return q;
	endfunction

	task automatic send_position(input logic [WORD_W-1:0] value);
		send_bytes(read_frame(dev_addr, read_fc, LEN_POSITION, {16'h0000, value}, 1'b0),
			POS_FRAME_BYTES);
	endtask

	task automatic send_speed(input logic [SPEED_W-1:0] value);
		send_bytes(read_frame(dev_addr, read_fc, LEN_SPEED, value, 1'b0), SPEED_FRAME_BYTES);
	endtask

	task automatic send_echo(input logic [WORD_W-1:0] reg_addr, input logic [WORD_W-1:0] value);
		send_bytes(echo_frame(dev_addr, write_fc, reg_addr, value), ECHO_FRAME_BYTES);
	endtask

	// lets the parser drain before its registers are touched
	task automatic wait_idle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_DEVICE_ADDRESS: dev_addr = data[BYTE_W-1:0];
			CFG_READ_CODE:      read_fc  = data[BYTE_W-1:0];
			CFG_WRITE_CODE:     write_fc = data[BYTE_W-1:0];
			CFG_POSITION_SPAN:  span     = data[SPAN_W-1:0];
			CFG_POSITION_HALF:  half     = data[HALF_W-1:0];
			default: ;
		endcase
	endtask

	// junk above the register width must be ignored
	task automatic set_config(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] rd,
		input logic [BYTE_W-1:0] wr, input logic [SPAN_W-1:0] sp, input logic [HALF_W-1:0] hf);
		wait_idle();
		write_reg(CFG_DEVICE_ADDRESS, {9'($urandom), addr});
		write_reg(CFG_READ_CODE, {9'($urandom), rd});
		write_reg(CFG_WRITE_CODE, {9'($urandom), wr});
		write_reg(CFG_POSITION_SPAN, sp);
		write_reg(CFG_POSITION_HALF, {2'($urandom), hf});
	endtask

	task automatic test_default_frames();
		send_position(16'h0123);
		send_speed(32'h1234_5678);
		send_echo(16'h0000, 16'hFFFF);
	endtask

	task automatic test_position_wrap();
		send_position(16'h0800);
		send_position(16'h0801);
		send_position(16'h7FFF);
		send_position(16'h8000);
		send_position(16'hFFFF);
		// span beyond its range, difference still fits the output width
		set_config(dev_addr, read_fc, write_fc, 17'h1FFFF, 15'd0);
		send_position(16'h7FFF);
		send_position(16'h0000);
	endtask

	task automatic test_speed_extremes();
		send_speed(32'h8000_0000);
		send_speed(32'h7FFF_FFFF);
	endtask

	task automatic test_echo_extremes();
		send_echo(16'hFFFF, 16'h0000);
	endtask

	task automatic test_resync();
		byte_q_t q;
		q = {};
		q = {q, dev_addr};
		q = {q, 8'h55};
		send_bytes(q, q.size());
		send_position(16'h0042);
		// corrupted crc, then a clean frame behind it
		send_bytes(read_frame(dev_addr, read_fc, LEN_SPEED, 32'hCAFE_F00D, 1'b1),
			SPEED_FRAME_BYTES);
		send_position(16'h0FFF);
		q = {};
		q = {q, dev_addr};
		q = {q, read_fc};
		q = {q, 8'h03};
		send_bytes(q, q.size());
		send_echo(16'h1234, 16'h5678);
		// cut-off frame followed by a complete one
		send_bytes(read_frame(dev_addr, read_fc, LEN_SPEED, 32'h0102_0304, 1'b0), 5);
		send_position(16'h0100);
	endtask

	task automatic test_equal_codes();
		set_config(8'hFF, 8'h10, 8'h10, 17'd4096, 15'd2048);
		send_echo(16'h0212, 16'h3400);
		send_position(16'h0900);
		send_speed(32'hFFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		set_config(8'h00, 8'hFF, 8'h00, 17'd65536, 15'd32767);
		write_reg(CFG_UNUSED, 17'($urandom));
		send_position(16'hFFFF);
		send_position(16'h7FFF);
		send_echo(16'hA5A5, 16'h5A5A);
		send_speed(32'h0000_0000);
		set_config(8'hFF, 8'h00, 8'hFF, 17'd1, 15'd0);
		send_position(16'h0001);
		send_echo(16'h0001, 16'h8000);
		set_config(8'h80, 8'h7F, 8'h01, 17'd0, 15'd0);
		send_position(16'h0005);
	endtask

	task automatic random_config();
		logic [BYTE_W-1:0] rd;
		logic [BYTE_W-1:0] wr;
		logic [SPAN_W-1:0] sp;
		rd = 8'($urandom);
		wr = ($urandom_range(0, 5) == 0) ? rd : 8'($urandom);
		sp = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 65536));
		set_config(8'($urandom), rd, wr, sp, 15'($urandom));
	endtask

	task automatic send_random_unit(output int count);
		byte_q_t           q;
		int                pick;
		logic [WORD_W-1:0] pos;
		logic [BYTE_W-1:0] len;
		pick  = $urandom_range(0, 99);
		len   = $urandom_range(0, 1) ? LEN_POSITION : LEN_SPEED;
		// positions near the wrap threshold are the interesting ones
		pos   = ($urandom_range(0, 2) == 0) ? WORD_W'(int'(half) + $urandom_range(0, 2) - 1)
		                                    : WORD_W'($urandom);
		if (pick < 35)
			q = read_frame(dev_addr, read_fc, LEN_POSITION, {16'h0000, pos}, 1'b0);
		else if (pick < 55)
			q = read_frame(dev_addr, read_fc, LEN_SPEED, $urandom, 1'b0);
		else if (pick < 72)
			q = echo_frame(dev_addr, write_fc, 16'($urandom), 16'($urandom));
		else if (pick < 80)
			q = read_frame(dev_addr, read_fc, len, $urandom, 1'b1);
		else if (pick < 86) begin
			q = {};
			q = {q, dev_addr};
			q = {q, read_fc};
			q = {q, 8'($urandom)};
		end else begin
			q = {};
			repeat ($urandom_range(1, 4))
				q = {q, (($urandom_range(0, 3) == 0) ? dev_addr : 8'($urandom))};
		end
		count = q.size();
		if (pick < 72 && $urandom_range(0, 9) == 0)
			count = $urandom_range(1, q.size() - 1);
		send_bytes(q, count);
	endtask

	task automatic test_random_traffic();
		int sent;
		int count;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config();
			calm = (phase == 2);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				send_random_unit(count);
				sent += count;
			end
		end
		calm = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [SPEED_W-1:0] want,
		input logic [SPEED_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && reply_ch.valid && reply_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply beat with none expected, actual kind %0h", $time,
					reply_ch.frame_kind);
				error_count++;
			end else begin
				want = pending_replies[0];
				pending_replies.delete(0);
				check_field("frame_kind", want.kind, reply_ch.frame_kind);
				check_field("position", want.position, reply_ch.position);
				check_field("speed_raw", want.speed, reply_ch.speed_raw);
				check_field("echo_register", want.echo_reg, reply_ch.echo_register);
				check_field("echo_value", want.echo_val, reply_ch.echo_value);
			end
		end
	end

	initial begin : reply_pacing
		int hold;
		hold           = 0;
		reply_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				reply_ch.ready <= 1'b0;
				hold--;
			end else begin
				reply_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 2) == 0)
					hold = pick_gap();
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		dev_addr      = RST_DEVICE_ADDRESS;
		read_fc       = RST_READ_CODE;
		write_fc      = RST_WRITE_CODE;
		span          = RST_POSITION_SPAN;
		half          = RST_POSITION_HALF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_frames();
		test_position_wrap();
		test_speed_extremes();
		test_echo_extremes();
		test_resync();
		test_equal_codes();
		test_register_extremes();
		test_random_traffic();

		wait_idle();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
